@@ hdl/lcar_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lcar_pkg: shared types and constants for the load cell reader
// Field widths, register map, phase codes and the tare divide constants.
// ============================================================================
package lcar_pkg;

    localparam int DATA_BITS    = 24;
    localparam int TARE_SAMPLES = 10;

    localparam int HP_W     = 16;
    localparam int GPC_W    = 24;
    localparam int THRUST_W = 32;
    localparam int THRUST_LSB = 16;
    localparam int MAG_W    = DATA_BITS + 1;
    localparam int PROD_W   = MAG_W + GPC_W;
    localparam int BIT_W    = $clog2(DATA_BITS + 2);
    localparam int TICK_W   = HP_W + 1;

    localparam int CNT_W    = $clog2(TARE_SAMPLES + 1);
    localparam int SUM_W    = DATA_BITS + $clog2(TARE_SAMPLES) + 1;

    // floor(x / TARE_SAMPLES) == (x * DIV_MULT) >> DIV_SHIFT for every
    // tare sum magnitude x; the shift leaves room for the rounding error.
    localparam int DIV_SHIFT = DATA_BITS + 2 * $clog2(TARE_SAMPLES);
    localparam longint unsigned DIV_MULT =
        ((64'd1 << DIV_SHIFT) + TARE_SAMPLES - 1) / TARE_SAMPLES;
    localparam int MULT_W   = $clog2(DIV_MULT + 1);
    localparam int DPROD_W  = SUM_W + MULT_W;

    localparam logic [HP_W-1:0]  HALF_RST = HP_W'(180);
    localparam logic [GPC_W-1:0] GPC_RST  = GPC_W'(83510);

    // APB register map: register index is paddr[2]
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam logic REG_HALF = 1'b0;
    localparam logic REG_GPC  = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } t_phase;

    typedef struct packed {
        logic                        clock_pin;
        logic                        sample_valid;
        logic signed [DATA_BITS-1:0] raw_count;
        logic                        tare_done;
        logic                        upd;
        logic [MAG_W-1:0]            mag;
    } t_item;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] sum;
    } t_div_req;

endpackage

@@ hdl/lcar_in_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lcar_in_if: input tick channel
// Carries one data line sample per item.
// ============================================================================
interface lcar_in_if;
    logic valid;
    logic ready;
    logic data_pin;

    modport source (output valid, output data_pin, input ready);
    modport sink   (input valid, input data_pin, output ready);
endinterface

@@ hdl/lcar_out_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lcar_out_if: result channel
// Carries the pin level, conversion word, tare status and weight per item.
// ============================================================================
interface lcar_out_if import lcar_pkg::*; ;
    logic                        valid;
    logic                        ready;
    logic                        clock_pin;
    logic                        sample_valid;
    logic signed [DATA_BITS-1:0] raw_count;
    logic                        tare_done;
    logic [THRUST_W-1:0]         thrust_q8;

    modport source (output valid, output clock_pin, output sample_valid,
                    output raw_count, output tare_done, output thrust_q8,
                    input ready);
    modport sink   (input valid, input clock_pin, input sample_valid,
                    input raw_count, input tare_done, input thrust_q8,
                    output ready);
endinterface

@@ hdl/load_cell_adc_reader_with_tare.sv @@
`timescale 1ns / 1ps
// ============================================================================
// load_cell_adc_reader_with_tare: two-wire 24-bit converter readout with tare
// Sequences the serial clock, shifts in each conversion, averages the first
// words into a tare offset and scales later words to an absolute weight.
// ============================================================================
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+---------------------------------------
//  i_in_ch   | in  | valid/ready        | data_pin
//  o_out_ch  | out | valid/ready        | clock_pin, sample_valid, raw_count,
//            |     |                    | tare_done, thrust_q8
//  APB       | in  | psel/penable/pready| paddr[2] picks half period or scale
//
//  Throughput is one item per clock while the output is taken; an accepted
//  item passes the sequencer, scale multiply and output registers in turn.
//  The 25x24 scale multiply sets the middle stage; the tare divide runs in
//  its own unit beside the pipeline.
//  Reset is synchronous and active low; it restores the register defaults,
//  returns the sequencer to waiting for ready and clears the tare.
//  A stalled output holds its item; the stages behind it fill, then input
//  ready drops until the output is taken.
// ============================================================================
module load_cell_adc_reader_with_tare import lcar_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lcar_in_if.sink            i_in_ch,
    lcar_out_if.source         o_out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [HP_W-1:0]  r_half;
    logic [GPC_W-1:0] r_gpc;
    logic             s_cfg_wr;

    assign pready   = 1'b1;
    assign s_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RST;
            r_gpc  <= GPC_RST;
        end else if (s_cfg_wr) begin
            unique case (paddr[2])
                REG_HALF: r_half <= pwdata[HP_W-1:0];
                REG_GPC:  r_gpc  <= pwdata[GPC_W-1:0];
                default:  r_half <= r_half;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_HALF: prdata = DATA_W'(r_half);
            REG_GPC:  prdata = DATA_W'(r_gpc);
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_ov;
    logic s_out_free, s_p2_free, s_p1_free;
    logic s_adv1, s_adv2, s_in_fire;

    assign s_out_free = !r_ov || o_out_ch.ready;
    assign s_adv2     = r_v2 && s_out_free;
    assign s_p2_free  = !r_v2 || s_out_free;
    assign s_adv1     = r_v1 && s_p2_free;
    assign s_p1_free  = !r_v1 || s_p2_free;
    assign s_in_fire  = i_in_ch.valid && s_p1_free;

    assign i_in_ch.ready = s_p1_free;

    // ------------------------------------------------------------------
    // Stage 0: pin sequencer and tare accumulation
    // ------------------------------------------------------------------
    t_phase                      r_phase, n_phase;
    logic [BIT_W-1:0]            r_bit, n_bit;
    logic [HP_W-1:0]             r_tick, n_tick;
    logic [DATA_BITS-1:0]        r_shift, n_shift;
    logic signed [SUM_W-1:0]     r_sum, n_sum;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic signed [DATA_BITS-1:0] r_last_raw, n_last_raw;

    logic [TICK_W-1:0]           s_hp;
    logic [TICK_W-1:0]           s_tick_inc;
    logic [BIT_W-1:0]            s_bit_inc;
    logic                        s_word_done;
    logic                        s_div_start;
    logic signed [DATA_BITS-1:0] s_raw;
    logic signed [DATA_BITS:0]   s_diff;
    logic signed [DATA_BITS-1:0] s_offset;
    logic                        s_div_busy;
    t_item                       s_item;
    t_div_req                    s_div_req;

    assign s_hp       = (r_half == '0) ? TICK_W'(1) : TICK_W'(r_half);
    assign s_tick_inc = TICK_W'(r_tick) + TICK_W'(1);
    assign s_bit_inc  = r_bit + BIT_W'(1);
    assign s_raw      = r_shift;
    assign s_diff     = {s_raw[DATA_BITS-1], s_raw} - {s_offset[DATA_BITS-1], s_offset};

    always_comb begin
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_tick      = r_tick;
        n_shift     = r_shift;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_last_raw  = r_last_raw;
        s_word_done = 1'b0;
        s_div_start = 1'b0;
        s_item      = '0;

        unique case (r_phase)
            PH_HIGH: begin
                s_item.clock_pin = 1'b1;
                n_tick = r_tick + HP_W'(1);
                if (s_tick_inc >= s_hp) begin
                    n_tick = '0;
                    if (r_bit < BIT_W'(DATA_BITS)) begin
                        n_shift = {r_shift[DATA_BITS-2:0], i_in_ch.data_pin};
                    end
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                n_tick = r_tick + HP_W'(1);
                if (s_tick_inc >= s_hp) begin
                    n_tick = '0;
                    n_bit  = s_bit_inc;
                    if (s_bit_inc >= BIT_W'(DATA_BITS + 1)) begin
                        s_word_done = 1'b1;
                        n_bit       = '0;
                        n_phase     = PH_WAIT;
                    end else begin
                        n_phase = PH_HIGH;
                    end
                end
            end
            default: begin
                // waiting for the converter to pull its data line low
                n_phase = PH_WAIT;
                if (!i_in_ch.data_pin) begin
                    n_phase = PH_HIGH;
                    n_tick  = '0;
                    n_bit   = '0;
                    n_shift = '0;
                end
            end
        endcase

        if (s_word_done) begin
            n_last_raw          = s_raw;
            s_item.sample_valid = 1'b1;
            if (r_cnt < CNT_W'(TARE_SAMPLES)) begin
                // still collecting tare words; launch the divide on the last
                n_sum = r_sum + {{(SUM_W - DATA_BITS){s_raw[DATA_BITS-1]}}, s_raw};
                n_cnt = r_cnt + CNT_W'(1);
                if (n_cnt == CNT_W'(TARE_SAMPLES)) begin
                    s_div_start = 1'b1;
                end
            end else begin
                s_item.upd = 1'b1;
                s_item.mag = s_diff[DATA_BITS] ? MAG_W'(-s_diff) : MAG_W'(s_diff);
            end
        end

        s_item.raw_count = n_last_raw;
        s_item.tare_done = (n_cnt == CNT_W'(TARE_SAMPLES));
    end

    assign s_div_req.start = s_in_fire & s_div_start;
    assign s_div_req.sum   = n_sum;

    lcar_tare_div u_tare_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (s_div_req),
        .o_offset (s_offset),
        .o_busy   (s_div_busy)
    );

    // Advance the sequencer only on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_bit      <= '0;
            r_tick     <= '0;
            r_shift    <= '0;
            r_sum      <= '0;
            r_cnt      <= '0;
            r_last_raw <= '0;
        end else if (s_in_fire) begin
            r_phase    <= n_phase;
            r_bit      <= n_bit;
            r_tick     <= n_tick;
            r_shift    <= n_shift;
            r_sum      <= n_sum;
            r_cnt      <= n_cnt;
            r_last_raw <= n_last_raw;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 -> 2: scale multiply; stage 2 -> output: pick the weight
    // ------------------------------------------------------------------
    t_item               r_p1, r_p2;
    logic [PROD_W-1:0]   r_prod2;
    logic [THRUST_W-1:0] r_last_thrust;
    logic [THRUST_W-1:0] s_thrust_new;

    logic                        r_o_clock_pin;
    logic                        r_o_sample_valid;
    logic signed [DATA_BITS-1:0] r_o_raw_count;
    logic                        r_o_tare_done;
    logic [THRUST_W-1:0]         r_o_thrust;

    assign s_thrust_new = r_prod2[THRUST_LSB +: THRUST_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_ov          <= 1'b0;
            r_last_thrust <= '0;
        end else begin
            if (s_p1_free) begin
                r_v1 <= s_in_fire;
            end
            if (s_p2_free) begin
                r_v2 <= s_adv1;
            end
            if (s_out_free) begin
                r_ov <= s_adv2;
            end
            if (s_adv2 && r_p2.upd) begin
                r_last_thrust <= s_thrust_new;
            end
        end
    end

    // payload registers: load with their stage
    always_ff @(posedge i_clk) begin
        if (s_in_fire) begin
            r_p1 <= s_item;
        end
        if (s_adv1) begin
            r_p2    <= r_p1;
            r_prod2 <= PROD_W'(r_p1.mag) * PROD_W'(r_gpc);
        end
        if (s_adv2) begin
            r_o_clock_pin    <= r_p2.clock_pin;
            r_o_sample_valid <= r_p2.sample_valid;
            r_o_raw_count    <= r_p2.raw_count;
            r_o_tare_done    <= r_p2.tare_done;
            r_o_thrust       <= r_p2.upd ? s_thrust_new : r_last_thrust;
        end
    end

    assign o_out_ch.valid        = r_ov;
    assign o_out_ch.clock_pin    = r_o_clock_pin;
    assign o_out_ch.sample_valid = r_o_sample_valid;
    assign o_out_ch.raw_count    = r_o_raw_count;
    assign o_out_ch.tare_done    = r_o_tare_done;
    assign o_out_ch.thrust_q8    = r_o_thrust;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The tare divide must finish long before the next word needs the offset.
    a_offset_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_fire && s_item.upd |-> !s_div_busy)
        else $error("tare offset used while divide in flight");

    // No weight is reported before the tare is established.
    a_no_thrust_before_tare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_o_tare_done |-> r_o_thrust == '0)
        else $error("nonzero weight before tare");

    // A completed word is never reported while the serial clock is high.
    a_word_clock_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_sample_valid |-> !r_o_clock_pin)
        else $error("word completion with serial clock high");

    // The pulse counter never runs past the gain-select pulse.
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= BIT_W'(DATA_BITS + 1))
        else $error("pulse counter out of range");

endmodule

@@ hdl/lcar_tare_div.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lcar_tare_div: tare offset divider
// Divides the signed tare sum by the sample count, truncating toward zero,
// through a three-stage reciprocal multiply.
// ============================================================================
module lcar_tare_div import lcar_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_div_req                    i_req,
    output logic signed [DATA_BITS-1:0] o_offset,
    output logic                        o_busy
);

    logic                  r_v1;
    logic                  r_neg1;
    logic [SUM_W-1:0]      r_abs1;
    logic                  r_v2;
    logic                  r_neg2;
    logic [DPROD_W-1:0]    r_prod2;
    logic signed [DATA_BITS-1:0] r_offset;

    logic [SUM_W-1:0]      n_abs1;
    logic [DATA_BITS:0]    s_quot;
    logic [DATA_BITS:0]    s_signed_quot;

    assign n_abs1 = i_req.sum[SUM_W-1] ? SUM_W'(-i_req.sum) : SUM_W'(i_req.sum);
    assign s_quot = r_prod2[DIV_SHIFT +: DATA_BITS + 1];
    assign s_signed_quot = r_neg2 ? (DATA_BITS + 1)'(-s_quot) : s_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_offset <= '0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_offset <= s_signed_quot[DATA_BITS-1:0];
            end
        end
    end

    // operand and product registers
    always_ff @(posedge i_clk) begin
        r_neg1  <= i_req.sum[SUM_W-1];
        r_abs1  <= n_abs1;
        r_neg2  <= r_neg1;
        r_prod2 <= DPROD_W'(r_abs1) * DPROD_W'(MULT_W'(DIV_MULT));
    end

    assign o_offset = r_offset;
    assign o_busy   = r_v1 | r_v2;

endmodule

@@ verif/load_cell_adc_reader_with_tare_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// load_cell_adc_reader_with_tare_checker: readout predictor and scoreboard
// Tracks register accesses and accepted ticks, predicts the pin level, word,
// tare status and weight of every tick, and compares them in order.
// ============================================================================
module load_cell_adc_reader_with_tare_checker import lcar_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lcar_in_if                i_in_mon,
    lcar_out_if               i_out_mon,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    input  logic [DATA_W-1:0] i_prdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int SHOW_MAX = 30;

    typedef struct packed {
        logic                 clock_pin;
        logic                 sample_valid;
        logic [DATA_BITS-1:0] raw_count;
        logic                 tare_done;
        logic [THRUST_W-1:0]  thrust_q8;
    } reading_t;

    logic [HP_W-1:0]      half_ticks;
    logic [GPC_W-1:0]     grams_scale;
    t_phase               seq_phase;
    int unsigned          tick_cnt;
    int unsigned          pulse_cnt;
    logic [DATA_BITS-1:0] shift_reg;
    int                   tare_acc;
    int                   tare_taken;
    int                   tare_off;
    logic [DATA_BITS-1:0] raw_hold;
    logic [THRUST_W-1:0]  weight_hold;
    reading_t             reading_q[$];
    int                   fail_cnt;

    assign o_fail_count = fail_cnt;

    task automatic log_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        if (fail_cnt < SHOW_MAX) begin
            $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        end
        fail_cnt++;
    endtask

    // take a finished word into the tare, or turn it into a weight
    function automatic void close_word();
        int              raw;
        longint          diff;
        longint unsigned mag;
        raw      = $signed(shift_reg);
        raw_hold = shift_reg;
        if (tare_taken < TARE_SAMPLES) begin
            tare_acc += raw;
            tare_taken++;
            if (tare_taken == TARE_SAMPLES) begin
                tare_off = tare_acc / TARE_SAMPLES;
            end
        end else begin
            diff = longint'(raw) - longint'(tare_off);
            mag  = (diff < 0) ? -diff : diff;
            weight_hold = THRUST_W'((mag * grams_scale) >> THRUST_LSB);
        end
    endfunction

    function automatic reading_t step_reader(input logic data_bit);
        reading_t    r;
        int unsigned hp;
        r.clock_pin    = 1'b0;
        r.sample_valid = 1'b0;
        hp = (half_ticks == '0) ? 1 : half_ticks;
        case (seq_phase)
            PH_HIGH: begin
                r.clock_pin = 1'b1;
                tick_cnt++;
                if (tick_cnt >= hp) begin
                    tick_cnt = 0;
                    if (pulse_cnt < DATA_BITS) begin
                        shift_reg = {shift_reg[DATA_BITS-2:0], data_bit};
                    end
                    seq_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                tick_cnt++;
                if (tick_cnt >= hp) begin
                    tick_cnt = 0;
                    pulse_cnt++;
                    if (pulse_cnt >= DATA_BITS + 1) begin
                        close_word();
                        r.sample_valid = 1'b1;
                        pulse_cnt      = 0;
                        seq_phase      = PH_WAIT;
                    end else begin
                        seq_phase = PH_HIGH;
                    end
                end
            end
            default: begin
                seq_phase = PH_WAIT;
                if (!data_bit) begin
                    seq_phase = PH_HIGH;
                    tick_cnt  = 0;
                    pulse_cnt = 0;
                    shift_reg = '0;
                end
            end
        endcase
        r.raw_count = raw_hold;
        r.tare_done = (tare_taken >= TARE_SAMPLES);
        r.thrust_q8 = weight_hold;
        return r;
    endfunction

    always @(posedge i_clk) begin
        reading_t          want;
        logic [DATA_W-1:0] reg_want;
        if (!i_rst_n) begin
            half_ticks  = HALF_RST;
            grams_scale = GPC_RST;
            seq_phase   = PH_WAIT;
            tick_cnt    = 0;
            pulse_cnt   = 0;
            shift_reg   = '0;
            tare_acc    = 0;
            tare_taken  = 0;
            tare_off    = 0;
            raw_hold    = '0;
            weight_hold = '0;
            reading_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_HALF) begin
                        half_ticks = i_pwdata[HP_W-1:0];
                    end else begin
                        grams_scale = i_pwdata[GPC_W-1:0];
                    end
                end else begin
                    reg_want = (i_paddr[2] == REG_HALF) ? DATA_W'(half_ticks)
                                                        : DATA_W'(grams_scale);
                    if (i_prdata !== reg_want) begin
                        log_mismatch("register readback", i_prdata, reg_want);
                    end
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (reading_q.size() == 0) begin
                    log_mismatch("result with nothing expected", 0, 0);
                end else begin
                    want = reading_q.pop_front();
                    if (i_out_mon.clock_pin !== want.clock_pin) begin
                        log_mismatch("clock_pin", i_out_mon.clock_pin, want.clock_pin);
                    end
                    if (i_out_mon.sample_valid !== want.sample_valid) begin
                        log_mismatch("sample_valid", i_out_mon.sample_valid,
                                     want.sample_valid);
                    end
                    if ($unsigned(i_out_mon.raw_count) !== want.raw_count) begin
                        log_mismatch("raw_count", $unsigned(i_out_mon.raw_count),
                                     want.raw_count);
                    end
                    if (i_out_mon.tare_done !== want.tare_done) begin
                        log_mismatch("tare_done", i_out_mon.tare_done, want.tare_done);
                    end
                    if (i_out_mon.thrust_q8 !== want.thrust_q8) begin
                        log_mismatch("thrust_q8", i_out_mon.thrust_q8, want.thrust_q8);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                reading_q.push_back(step_reader(i_in_mon.data_pin));
            end
        end
        o_pending <= reading_q.size();
    end

endmodule

@@ verif/load_cell_adc_reader_with_tare_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// load_cell_adc_reader_with_tare_tb: stimulus and verdict for the readout
// Feeds data line ticks and register accesses to the block; the checker
// beside it predicts every result and counts mismatches.
// ============================================================================
//
//  Run outline:
//    - reset, read back the register defaults
//    - start a conversion at the default half period, then stretch the half
//      period to its maximum and drop it to zero in the middle of a pulse
//    - ten tare words with the field extremes and a negative, inexact sum
//    - weights at full scale and an exactly tared word
//    - short random phases at other half periods and scales
//  Each input item is one tick; every tick gives exactly one result.
// ============================================================================
module load_cell_adc_reader_with_tare_tb;
    import lcar_pkg::*;

    typedef enum int {
        PAT_RANDOM,
        PAT_HIGH,
        PAT_LOW
    } t_pin_pattern;

    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   PHASE_TICKS   = 12;
    localparam int   PHASE_WORDS   = 0;
    localparam int   RAND_PHASES   = 2;
    localparam logic APB_WRITE     = 1'b1;
    localparam logic APB_READ      = 1'b0;
    localparam logic [ADDR_W-1:0] ADDR_HALF = {REG_HALF, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_GPC  = {REG_GPC, 2'b00};
    localparam logic [DATA_W-1:0] HALF_MAX  = DATA_W'(16'hFFFF);
    localparam logic [DATA_W-1:0] GPC_MAX   = DATA_W'(24'hFFFFFF);

    // tare words; with the all-ones word of the opening flush the sum is
    // -33554435, so the offset truncates up to -3355443 (0xCCCCCD)
    localparam logic [DATA_BITS-1:0] TARE_WORDS [9] = '{
        24'h7FFFFF, 24'h800000, 24'h000000, 24'h800000, 24'h800000,
        24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF
    };
    localparam logic [DATA_BITS-1:0] TARED_WORD = 24'hCCCCCD;

    // half period used by each random phase; zero means one
    localparam int unsigned RAND_HALF [RAND_PHASES] = '{2, 0};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   fail_count;
    int   pending;
    int   cycle_cnt  = 0;
    int   stall_left = 0;
    int   words_seen = 0;
    int   ticks_sent = 0;
    logic calm;

    lcar_in_if  in_ch ();
    lcar_out_if out_ch ();

    load_cell_adc_reader_with_tare u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    load_cell_adc_reader_with_tare_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: drop ready in random bursts; hold it high through reset and
    // the calm tail of the run.
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= (stall_left == 1);
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left   <= $urandom_range(1, 10);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Count finished conversions and guard against a hung run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (out_ch.valid && out_ch.ready && out_ch.sample_valid) begin
            words_seen <= words_seen + 1;
        end
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("** load_cell_adc_reader_with_tare: FAILED **");
            $finish;
        end
    end

    // Offer one tick, with a random gap ahead of it outside the calm tail,
    // and hold it until the block takes it.
    task automatic push_tick(input logic level);
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.data_pin <= level;
        do @(posedge i_clk); while (!in_ch.ready);
        ticks_sent++;
    endtask

    // Stop sending, wait for every predicted result, then let the pipeline
    // and the tare divide settle before any register write.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer; back-to-back transfers skip the idle state, so
    // release the bus with bus_park after the last one.
    task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic bus_park();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drive one well-formed conversion from the waiting state: a low tick to
    // start, then each bit held for its whole pulse, MSB first.
    task automatic send_word(input logic [DATA_BITS-1:0] word, input int hp);
        logic level;
        push_tick(1'b0);
        for (int b = 0; b < DATA_BITS + 1; b++) begin
            level = (b < DATA_BITS) ? word[DATA_BITS-1-b] : 1'b1;
            repeat (2 * hp) push_tick(level);
        end
    endtask

    // Random ticks in bursts: mostly random levels, which start and fill
    // conversions, plus held-high stretches (long waits, all-ones words)
    // and held-low stretches (instant starts, all-zeros words).
    task automatic run_random(input int min_ticks, input int min_words);
        int           first_tick;
        int           first_word;
        int           burst;
        t_pin_pattern pat;
        first_tick = ticks_sent;
        first_word = words_seen;
        while (ticks_sent - first_tick < min_ticks || words_seen - first_word < min_words) begin
            burst = $urandom_range(1, 20);
            case ($urandom_range(0, 9))
                0, 1: pat = PAT_HIGH;
                2: pat = PAT_LOW;
                default: pat = PAT_RANDOM;
            endcase
            repeat (burst) begin
                case (pat)
                    PAT_HIGH: push_tick(1'b1);
                    PAT_LOW: push_tick(1'b0);
                    default: push_tick(1'($urandom_range(0, 1)));
                endcase
            end
        end
    endtask

    initial begin
        logic [DATA_W-1:0] scale;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.data_pin <= 1'b1;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        calm           <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // check the register defaults
        reg_access(APB_READ, ADDR_HALF, '0);
        reg_access(APB_READ, ADDR_GPC, '0);
        bus_park();

        // idle with the line high, start a conversion and stop early in the
        // first high half at the default half period
        repeat (3) push_tick(1'b1);
        push_tick(1'b0);
        repeat (4) push_tick(1'b1);

        // stretch the half period mid-pulse, advance a little, then drop it to
        // zero: the count has already passed it, so the half ends at once
        drain();
        reg_access(APB_WRITE, ADDR_HALF, HALF_MAX);
        bus_park();
        repeat (2) push_tick(1'b1);
        drain();
        reg_access(APB_WRITE, ADDR_HALF, '0);
        reg_access(APB_READ, ADDR_HALF, '0);
        bus_park();

        // flush the conversion with the line high: an all-ones first tare word
        repeat (52) push_tick(1'b1);

        // remaining tare words at the shortest half period
        drain();
        reg_access(APB_WRITE, ADDR_HALF, 32'd1);
        bus_park();
        foreach (TARE_WORDS[k]) send_word(TARE_WORDS[k], 1);

        // full scale with junk in the upper write bits; extreme weights and a
        // word equal to the offset
        drain();
        reg_access(APB_WRITE, ADDR_GPC, 32'hA500_0000 | GPC_MAX);
        reg_access(APB_READ, ADDR_GPC, '0);
        bus_park();
        send_word(24'h7FFFFF, 1);
        send_word(24'h800000, 1);
        send_word(TARED_WORD, 1);

        // random phases; each boundary lands wherever the sequencer happens
        // to be, so half period changes fall mid-pulse too
        for (int p = 0; p < RAND_PHASES; p++) begin
            scale = (p == 1) ? DATA_W'(GPC_RST) : DATA_W'($urandom_range(0, 24'hFFFFFF));
            drain();
            if (p == RAND_PHASES - 1) begin
                calm <= 1'b1;
            end
            reg_access(APB_WRITE, ADDR_HALF, DATA_W'(RAND_HALF[p]));
            reg_access(APB_WRITE, ADDR_GPC, scale);
            reg_access(APB_READ, ADDR_HALF, '0);
            reg_access(APB_READ, ADDR_GPC, '0);
            bus_park();
            run_random(PHASE_TICKS, PHASE_WORDS);
        end

        drain();

        $display("covered %0d ticks and %0d conversions, tare from a negative inexact sum,",
                 ticks_sent, words_seen);
        $display("half periods 0 to 65535 with mid-pulse changes, full scale and tared weights");
        if (fail_count == 0) begin
            $display("** load_cell_adc_reader_with_tare: PASSED **");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("** load_cell_adc_reader_with_tare: FAILED **");
        end
        $finish;
    end

endmodule
